// ===== sv/pidt_pkg.sv =====
package pidt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int GAIN_W         = 32;
    localparam int POLE_W         = 31;
    localparam int GAIN_FRAC      = 24;
    localparam int POLE_FRAC      = 30;
    localparam int CFG_INDEX_W    = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_COEFF = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_POLE  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MAX     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_MIN     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_MAX   = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_MIN   = 3'd7;

    // limits in q.16, gains in q8.24
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 32'd33554432;
    localparam int OUT_MAX_RST   = 13107200;
    localparam int OUT_MIN_RST   = -13107200;
    localparam int INTEG_MAX_RST = 16711680;
    localparam int INTEG_MIN_RST = -16711680;

    typedef struct packed {
        logic integ_clamped;
        logic out_clamped;
    } pidt_flags_t;

endpackage

// ===== sv/pidt_core.sv =====
module pidt_core
    import pidt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic signed [DATA_WIDTH-1:0] measured,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic signed [DATA_WIDTH-1:0] integ_state,
    input  logic signed [DATA_WIDTH-1:0] prev_error,
    input  logic signed [DATA_WIDTH-1:0] last_measured,
    input  logic signed [DATA_WIDTH-1:0] deriv_state,
    input  logic        [GAIN_W-1:0]     prop_gain,
    input  logic        [GAIN_W-1:0]     integ_coeff,
    input  logic        [GAIN_W-1:0]     deriv_gain,
    input  logic signed [POLE_W-1:0]     deriv_pole,
    input  logic signed [DATA_WIDTH-1:0] out_max,
    input  logic signed [DATA_WIDTH-1:0] out_min,
    input  logic signed [DATA_WIDTH-1:0] integ_max,
    input  logic signed [DATA_WIDTH-1:0] integ_min,
    output logic signed [DATA_WIDTH-1:0] drive,
    output pidt_flags_t                  flags,
    output logic signed [DATA_WIDTH-1:0] integ_next,
    output logic signed [DATA_WIDTH-1:0] error_next,
    output logic signed [DATA_WIDTH-1:0] deriv_next
);

    localparam int W = DATA_WIDTH;

    logic signed [W:0]        err_diff;
    logic signed [W:0]        err_sum;
    logic signed [W:0]        meas_diff;
    logic signed [W+32:0]     p_prod;
    logic signed [W+33:0]     i_prod;
    logic signed [W+33:0]     a_prod;
    logic signed [W+30:0]     b_prod;
    logic signed [W+8:0]      p_term;
    logic signed [W+9:0]      i_inc;
    logic signed [W+9:0]      a_term;
    logic signed [W:0]        b_term;
    logic signed [W+10:0]     i_sum;
    logic signed [W+10:0]     ab_sum;
    logic signed [W+11:0]     d_raw;
    logic signed [W+10:0]     o_sum;
    logic signed [W+11:0]     d_max;
    logic signed [W+11:0]     d_min;
    logic                     integ_hit;
    logic                     out_hit;

    assign d_max = $signed({{13{1'b0}}, {(W-1){1'b1}}});
    assign d_min = $signed({{13{1'b1}}, {(W-1){1'b0}}});

    // error with saturation
    assign err_diff = (W+1)'(target) - (W+1)'(measured);

    always_comb
    begin
        if (err_diff[W] != err_diff[W-1])
        begin
            error_next = err_diff[W] ? $signed({1'b1, {(W-1){1'b0}}})
                                     : $signed({1'b0, {(W-1){1'b1}}});
        end
        else
        begin
            error_next = err_diff[W-1:0];
        end
    end

    // proportional term
    assign p_prod = error_next * $signed({1'b0, prop_gain});
    assign p_term = p_prod[W+32:GAIN_FRAC];

    // trapezoidal integrator
    assign err_sum = (W+1)'(error_next) + (W+1)'(prev_error);
    assign i_prod  = err_sum * $signed({1'b0, integ_coeff});
    assign i_inc   = i_prod[W+33:GAIN_FRAC];
    assign i_sum   = (W+11)'(integ_state) + (W+11)'(i_inc);

    always_comb
    begin
        integ_hit = 1'b0;
        integ_next = i_sum[W-1:0];
        if (i_sum > (W+11)'(integ_max))
        begin
            integ_next = integ_max;
            integ_hit = 1'b1;
        end
        else if (i_sum < (W+11)'(integ_min))
        begin
            integ_next = integ_min;
            integ_hit = 1'b1;
        end
    end

    // filtered derivative on measurement
    assign meas_diff = (W+1)'(measured) - (W+1)'(last_measured);
    assign a_prod    = meas_diff * $signed({1'b0, deriv_gain});
    assign a_term    = a_prod[W+33:GAIN_FRAC];
    assign b_prod    = deriv_state * deriv_pole;
    assign b_term    = b_prod[W+30:POLE_FRAC];
    assign ab_sum    = (W+11)'(a_term) + (W+11)'(b_term);
    assign d_raw     = -((W+12)'(ab_sum));

    always_comb
    begin
        if (d_raw > d_max)
        begin
            deriv_next = d_max[W-1:0];
        end
        else if (d_raw < d_min)
        begin
            deriv_next = d_min[W-1:0];
        end
        else
        begin
            deriv_next = d_raw[W-1:0];
        end
    end

    // output sum and clamp
    assign o_sum = (W+11)'(p_term) + (W+11)'(integ_next) + (W+11)'(deriv_next);

    always_comb
    begin
        out_hit = 1'b0;
        drive = o_sum[W-1:0];
        if (o_sum > (W+11)'(out_max))
        begin
            drive = out_max;
            out_hit = 1'b1;
        end
        else if (o_sum < (W+11)'(out_min))
        begin
            drive = out_min;
            out_hit = 1'b1;
        end
    end

    assign flags = {integ_hit, out_hit};

endmodule

// ===== sv/pid_controller_tustin.sv =====
// PID controller, one sample per stream transfer: error = target - measured, a
// trapezoidal integrator clamped to its limits, and a first-order filtered
// derivative on the measurement, with the drive clamped to the output limits and
// flagged in tuser when a clamp applies. All data is signed Q(DATA_WIDTH-16).16.
// The block takes one sample every clock cycle while the output side is not
// stalled; a sample is held in the input register and then moves to the result
// register, which presents it until the output side takes it. The rate is set
// by the update of the integrator and derivative state, whose feedback runs
// through the clamp adders and, for the derivative, one multiplier. Configuration
// writes are always ready and should be made while no sample is in flight.
module pid_controller_tustin
    import pidt_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // measured, target
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // drive
    output logic [((DATA_WIDTH+7)/8)*8-1:0]         m_tdata,
    // out_clamped, integ_clamped
    output logic [1:0]                              m_tuser,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [CFG_INDEX_W-1:0]                  cfg_index,
    input  logic [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int OUT_W = ((W + 7) / 8) * 8;

    logic                  in_valid_reg;
    logic signed [W-1:0]   meas_reg;
    logic signed [W-1:0]   tgt_reg;
    logic                  advance;

    logic [GAIN_W-1:0]     prop_gain_reg;
    logic [GAIN_W-1:0]     integ_coeff_reg;
    logic [GAIN_W-1:0]     deriv_gain_reg;
    logic signed [POLE_W-1:0] deriv_pole_reg;
    logic signed [W-1:0]   out_max_reg;
    logic signed [W-1:0]   out_min_reg;
    logic signed [W-1:0]   integ_max_reg;
    logic signed [W-1:0]   integ_min_reg;

    logic signed [W-1:0]   integ_reg;
    logic signed [W-1:0]   prev_error_reg;
    logic signed [W-1:0]   last_meas_reg;
    logic signed [W-1:0]   deriv_reg;

    logic signed [W-1:0]   integ_next;
    logic signed [W-1:0]   error_next;
    logic signed [W-1:0]   deriv_next;
    logic signed [W-1:0]   drive_next;
    pidt_flags_t           flags_next;

    logic                  out_valid_reg;
    logic [W-1:0]          drive_reg;
    pidt_flags_t           flags_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_coeff_reg <= '0;
            deriv_gain_reg  <= '0;
            deriv_pole_reg  <= '0;
            out_max_reg     <= W'(OUT_MAX_RST);
            out_min_reg     <= W'(OUT_MIN_RST);
            integ_max_reg   <= W'(INTEG_MAX_RST);
            integ_min_reg   <= W'(INTEG_MIN_RST);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_COEFF: integ_coeff_reg <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data[GAIN_W-1:0];
                REG_DERIV_POLE:  deriv_pole_reg  <= cfg_data[POLE_W-1:0];
                REG_OUT_MAX:     out_max_reg     <= cfg_data[W-1:0];
                REG_OUT_MIN:     out_min_reg     <= cfg_data[W-1:0];
                REG_INTEG_MAX:   integ_max_reg   <= cfg_data[W-1:0];
                REG_INTEG_MIN:   integ_min_reg   <= cfg_data[W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            meas_reg <= s_tdata[W-1:0];
            tgt_reg  <= s_tdata[2*W-1:W];
        end
    end

    pidt_core #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_core (
        .measured      (meas_reg),
        .target        (tgt_reg),
        .integ_state   (integ_reg),
        .prev_error    (prev_error_reg),
        .last_measured (last_meas_reg),
        .deriv_state   (deriv_reg),
        .prop_gain     (prop_gain_reg),
        .integ_coeff   (integ_coeff_reg),
        .deriv_gain    (deriv_gain_reg),
        .deriv_pole    (deriv_pole_reg),
        .out_max       (out_max_reg),
        .out_min       (out_min_reg),
        .integ_max     (integ_max_reg),
        .integ_min     (integ_min_reg),
        .drive         (drive_next),
        .flags         (flags_next),
        .integ_next    (integ_next),
        .error_next    (error_next),
        .deriv_next    (deriv_next)
    );

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg      <= '0;
            prev_error_reg <= '0;
            last_meas_reg  <= '0;
            deriv_reg      <= '0;
        end
        else if (advance)
        begin
            integ_reg      <= integ_next;
            prev_error_reg <= error_next;
            last_meas_reg  <= meas_reg;
            deriv_reg      <= deriv_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drive_reg <= drive_next;
            flags_reg <= flags_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(drive_reg);
    assign m_tuser  = {flags_reg.integ_clamped, flags_reg.out_clamped};

    // a clamped output sits on one of the limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && flags_reg.out_clamped |->
            $signed(drive_reg) == out_max_reg || $signed(drive_reg) == out_min_reg)
        else $error("clamped drive not at a limit");

    // an unclamped output lies inside ordered limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !flags_reg.out_clamped && (out_min_reg <= out_max_reg) |->
            $signed(drive_reg) <= out_max_reg && $signed(drive_reg) >= out_min_reg)
        else $error("unclamped drive outside limits");

    // a sample leaving the input stage always shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after transfer");

    // a sample held by a stalled output is kept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=>
            in_valid_reg && $stable(meas_reg) && $stable(tgt_reg))
        else $error("pending sample dropped during stall");

endmodule
